// File: rtl/core/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the masked pattern priority match
// Word layouts, command and status codes, and derived widths of the cell chain.
// ----------------------------------------------------------------------------
package pmm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int WORD_BITS   = 32;

   // fixed field widths of the words on the ports
   localparam int CMD_W       = 2;
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 8;
   localparam int OPS_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int IDX_OUT_W   = 6;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] word;
      logic [DATA_W-1:0] mask_in;
      logic [KIND_W-1:0] kind_in;
      logic [OPS_W-1:0]  ops_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 hit;
      logic [IDX_OUT_W-1:0] index;
      logic [KIND_W-1:0]    kind_out;
      logic [OPS_W-1:0]     ops_out;
   } rsp_type;

   // entry write, broadcast to every cell
   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     idx;
      logic [WORD_BITS-1:0] sig;
      logic [WORD_BITS-1:0] mask;
      logic [KIND_W-1:0]    kind;
      logic [OPS_W-1:0]     ops;
   } wr_type;

   // word traveling down the chain; fill is the table size seen at accept
   typedef struct packed {
      logic                 valid;
      logic                 lookup;
      logic [WORD_BITS-1:0] word;
      logic [FILL_W-1:0]    fill;
      rsp_type              rsp;
   } token_type;

endpackage

// File: rtl/core/pmm_cell.sv
// ----------------------------------------------------------------------------
// pmm_cell: one table entry and one stage of the lookup chain
// Holds signature, mask, type and operand count of one position, compares the
// passing word against it and overrides the carried result on a match.
// ----------------------------------------------------------------------------
module pmm_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [pmm_pkg::IDX_W-1:0] cell_idx,
   input  pmm_pkg::wr_type           wr,
   input  pmm_pkg::token_type        prev_tok,
   output pmm_pkg::token_type        next_tok
);

   logic [pmm_pkg::WORD_BITS-1:0] sig_ff, sig_in;
   logic [pmm_pkg::WORD_BITS-1:0] mask_ff, mask_in;
   logic [pmm_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [pmm_pkg::OPS_W-1:0]     ops_ff, ops_in;
   pmm_pkg::token_type            tok_ff, tok_in;
   logic                          match;

   always_comb begin
      sig_in  = sig_ff;
      mask_in = mask_ff;
      kind_in = kind_ff;
      ops_in  = ops_ff;
      if (wr.en && (wr.idx == cell_idx)) begin
         sig_in  = wr.sig;
         mask_in = wr.mask;
         kind_in = wr.kind;
         ops_in  = wr.ops;
      end
   end

   // positions at or above the snapshot fill are not live for this word
   assign match = prev_tok.lookup
                  && (pmm_pkg::FILL_W'(cell_idx) < prev_tok.fill)
                  && ((prev_tok.word & mask_ff) == sig_ff);

   // chain runs upward, so the last match seen is the newest entry
   always_comb begin
      tok_in = prev_tok;
      if (match) begin
         tok_in.rsp.status   = pmm_pkg::ST_OK;
         tok_in.rsp.hit      = 1'b1;
         tok_in.rsp.index    = pmm_pkg::IDX_OUT_W'(cell_idx);
         tok_in.rsp.kind_out = kind_ff;
         tok_in.rsp.ops_out  = ops_ff;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff  <= sig_in;
      mask_ff <= mask_in;
      kind_ff <= kind_in;
      ops_ff  <= ops_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

// File: rtl/core/masked_pattern_priority_match_top.sv
// ----------------------------------------------------------------------------
// masked_pattern_priority_match_top: ternary match decode table
// Loads append signature/mask entries unless full, lookups return the newest entry with
// (word & mask) == signature, clears empty the table.
//
//   channel | dir | data            | handshake
//   req     | in  | req_data        | req_valid / req_stall
//   rsp     | out | rsp_data        | rsp_valid / rsp_stall
//
// Every word crosses a chain of TABLE_DEPTH cells, each of which registers it,
// and the result leaves the last cell; one word per cycle enters while the
// chain is not frozen. Cell compares run side by side.
// Reset clears the fill count and the chain valids; entries are not cleared.
// A stalled result freezes the whole chain and raises req_stall.
// ----------------------------------------------------------------------------
module masked_pattern_priority_match_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pmm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pmm_pkg::rsp_type rsp_data
);

   logic [pmm_pkg::FILL_W-1:0] fill_count_ff, fill_count_in;
   logic                       advance;
   logic                       accept;
   logic                       full;
   pmm_pkg::wr_type            wr;
   pmm_pkg::token_type         tok [pmm_pkg::TABLE_DEPTH+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign full      = (fill_count_ff == pmm_pkg::FILL_W'(pmm_pkg::TABLE_DEPTH));

   // head of the chain: loads, clears and misses are answered here
   always_comb begin
      tok[0]        = '0;
      tok[0].valid  = req_valid;
      tok[0].lookup = req_valid && (req_data.cmd == pmm_pkg::CMD_LOOKUP);
      tok[0].word   = pmm_pkg::WORD_BITS'(req_data.word);
      tok[0].fill   = fill_count_ff;
      case (req_data.cmd)
         pmm_pkg::CMD_LOAD:   tok[0].rsp.status = full ? pmm_pkg::ST_FULL : pmm_pkg::ST_OK;
         pmm_pkg::CMD_LOOKUP: tok[0].rsp.status = pmm_pkg::ST_MISS;
         default:             tok[0].rsp.status = pmm_pkg::ST_OK;
      endcase
   end

   always_comb begin
      wr.en   = accept && (req_data.cmd == pmm_pkg::CMD_LOAD) && !full;
      wr.idx  = pmm_pkg::IDX_W'(fill_count_ff);
      wr.sig  = pmm_pkg::WORD_BITS'(req_data.word);
      wr.mask = pmm_pkg::WORD_BITS'(req_data.mask_in);
      wr.kind = req_data.kind_in;
      wr.ops  = req_data.ops_in;
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (accept) begin
         case (req_data.cmd)
            pmm_pkg::CMD_LOAD: begin
               if (!full) begin
                  fill_count_in = fill_count_ff + pmm_pkg::FILL_W'(1);
               end
            end
            pmm_pkg::CMD_CLEAR: fill_count_in = '0;
            default:            fill_count_in = fill_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   for (genvar i = 0; i < pmm_pkg::TABLE_DEPTH; i++) begin : g_cell
      pmm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (pmm_pkg::IDX_W'(i)),
         .wr       (wr),
         .prev_tok (tok[i]),
         .next_tok (tok[i+1])
      );
   end

   assign rsp_valid = tok[pmm_pkg::TABLE_DEPTH].valid;
   assign rsp_data  = tok[pmm_pkg::TABLE_DEPTH].rsp;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= pmm_pkg::FILL_W'(pmm_pkg::TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_full_load_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == pmm_pkg::CMD_LOAD) && full) |=> $stable(fill_count_ff))
      else $error("refused load changed the fill count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == pmm_pkg::CMD_CLEAR)) |=> (fill_count_ff == '0))
      else $error("clear did not empty the table");

   a_stall_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !accept)
      else $error("word accepted while the chain is frozen");

   a_hit_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.status == pmm_pkg::ST_OK))
      else $error("hit reported with a non-ok status");

endmodule
